// File: rtl/core/srt_pkg.sv
package srt_pkg;

	// CORDIC datapath widths: x, y in Q2.30 with headroom, z in 2^32 per turn
	localparam int XY_W          = 34;
	localparam int Z_W           = 34;
	localparam int SCALE_W       = 16;
	localparam int SHIFT_W       = 32;
	localparam int ANGLE_W       = 16;
	localparam int TERM_W        = 16;
	localparam int PROD_W        = XY_W + SCALE_W;
	localparam int ATAN_ENTRIES  = 24;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032875;

	// Operands that ride along the CORDIC stages
	typedef struct packed {
		logic signed [SCALE_W-1:0] scale_x;
		logic signed [SCALE_W-1:0] scale_y;
		logic signed [SHIFT_W-1:0] shift_x;
		logic signed [SHIFT_W-1:0] shift_y;
		logic                      flip;
	} side_t;

	// atan(2^-i), 2^32 per turn, rounded to nearest
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] v;
		case (i)
			0:       v = 32'd536870912;
			1:       v = 32'd316933406;
			2:       v = 32'd167458907;
			3:       v = 32'd85004756;
			4:       v = 32'd42667331;
			5:       v = 32'd21354465;
			6:       v = 32'd10679838;
			7:       v = 32'd5340245;
			8:       v = 32'd2670163;
			9:       v = 32'd1335087;
			10:      v = 32'd667544;
			11:      v = 32'd333772;
			12:      v = 32'd166886;
			13:      v = 32'd83443;
			14:      v = 32'd41722;
			15:      v = 32'd20861;
			16:      v = 32'd10430;
			17:      v = 32'd5215;
			18:      v = 32'd2608;
			19:      v = 32'd1304;
			20:      v = 32'd652;
			21:      v = 32'd326;
			22:      v = 32'd163;
			23:      v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/core/srt_in_if.sv
interface srt_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [srt_pkg::SCALE_W-1:0]    scale_x;
	logic signed [srt_pkg::SCALE_W-1:0]    scale_y;
	logic        [srt_pkg::ANGLE_W-1:0]    angle;
	logic signed [srt_pkg::SHIFT_W-1:0]    shift_x;
	logic signed [srt_pkg::SHIFT_W-1:0]    shift_y;

	modport source (output valid, scale_x, scale_y, angle, shift_x, shift_y, input ready);
	modport sink (input valid, scale_x, scale_y, angle, shift_x, shift_y, output ready);
endinterface

// File: rtl/core/srt_out_if.sv
interface srt_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [srt_pkg::TERM_W-1:0]     m_row0_col0;
	logic signed [srt_pkg::TERM_W-1:0]     m_row0_col1;
	logic signed [srt_pkg::SHIFT_W-1:0]    m_row0_col2;
	logic signed [srt_pkg::TERM_W-1:0]     m_row1_col0;
	logic signed [srt_pkg::TERM_W-1:0]     m_row1_col1;
	logic signed [srt_pkg::SHIFT_W-1:0]    m_row1_col2;

	modport source (output valid, m_row0_col0, m_row0_col1, m_row0_col2,
		m_row1_col0, m_row1_col1, m_row1_col2, input ready);
	modport sink (input valid, m_row0_col0, m_row0_col1, m_row0_col2,
		m_row1_col0, m_row1_col1, m_row1_col2, output ready);
endinterface

// File: rtl/core/srt_cordic_stage.sv
module srt_cordic_stage #(
	parameter int STEP = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              valid_in,
	input  logic signed [srt_pkg::XY_W-1:0]   x_in,
	input  logic signed [srt_pkg::XY_W-1:0]   y_in,
	input  logic signed [srt_pkg::Z_W-1:0]    z_in,
	input  srt_pkg::side_t                    side_in,
	output logic                              valid_out,
	output logic signed [srt_pkg::XY_W-1:0]   x_out,
	output logic signed [srt_pkg::XY_W-1:0]   y_out,
	output logic signed [srt_pkg::Z_W-1:0]    z_out,
	output srt_pkg::side_t                    side_out
);
	import srt_pkg::*;

	localparam logic signed [Z_W-1:0] ATAN_STEP =
		signed'({{(Z_W-32){1'b0}}, atan_turn(STEP)});

	logic                     pos;
	logic signed [XY_W-1:0]   dx;
	logic signed [XY_W-1:0]   dy;
	logic                     valid_s1;
	logic signed [XY_W-1:0]   x_s1;
	logic signed [XY_W-1:0]   y_s1;
	logic signed [Z_W-1:0]    z_s1;
	side_t                    side_s1;

	assign pos = !z_in[Z_W-1];
	assign dx  = y_in >>> STEP;
	assign dy  = x_in >>> STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= pos ? x_in - dx : x_in + dx;
			y_s1    <= pos ? y_in + dy : y_in - dy;
			z_s1    <= pos ? z_in - ATAN_STEP : z_in + ATAN_STEP;
			side_s1 <= side_in;
		end
	end

	assign valid_out = valid_s1;
	assign x_out     = x_s1;
	assign y_out     = y_s1;
	assign z_out     = z_s1;
	assign side_out  = side_s1;
endmodule

// File: rtl/core/srt_texture_matrix.sv
// Channel  Role   Word
// -------  -----  --------------------------------------------------
// srt      sink   scale_x, scale_y, angle, shift_x, shift_y
// mtx      source m_row0_col0..m_row1_col2 (2x3 matrix, one per srt word)
//
// Pipeline: angle fold, one stage per CORDIC iteration, product, then
// round/saturate into the output register. One word is taken every cycle
// while the output word is not held; the pipeline of CORDIC stages sets the depth.
// arst_n clears the valid bits only. When the output word waits, the whole
// pipeline holds and srt.ready drops; a free output slot lets it advance.
module srt_texture_matrix #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	srt_in_if.sink srt,
	srt_out_if.source mtx
);
	import srt_pkg::*;

	localparam int N = CORDIC_ITERATIONS;
	localparam logic signed [PROD_W+1:0] ROUND_HALF = (PROD_W+2)'(64'sd536870912);

	function automatic logic signed [TERM_W-1:0] round_sat(
		input logic signed [PROD_W+1:0] p
	);
		logic signed [PROD_W+1:0] r;
		logic signed [TERM_W-1:0] v;
		r = (p + ROUND_HALF) >>> 30;
		if (r > (PROD_W+2)'(32767)) begin
			v = 16'sh7fff;
		end else if (r < -(PROD_W+2)'(32768)) begin
			v = 16'sh8000;
		end else begin
			v = r[TERM_W-1:0];
		end
		return v;
	endfunction

	logic                     adv;
	logic                     fold_flip;
	logic [ANGLE_W-1:0]       fold_angle;

	logic                     valid_p [N+1];
	logic signed [XY_W-1:0]   x_p [N+1];
	logic signed [XY_W-1:0]   y_p [N+1];
	logic signed [Z_W-1:0]    z_p [N+1];
	side_t                    side_p [N+1];

	logic signed [XY_W-1:0]   cos_v;
	logic signed [XY_W-1:0]   sin_v;

	logic                     valid_m_s1;
	logic signed [PROD_W-1:0] p00_s1;
	logic signed [PROD_W-1:0] p01_s1;
	logic signed [PROD_W-1:0] p10_s1;
	logic signed [PROD_W-1:0] p11_s1;
	logic signed [SHIFT_W-1:0] shx_s1;
	logic signed [SHIFT_W-1:0] shy_s1;

	logic                     valid_o_s2;
	logic signed [TERM_W-1:0] m00_s2;
	logic signed [TERM_W-1:0] m01_s2;
	logic signed [TERM_W-1:0] m10_s2;
	logic signed [TERM_W-1:0] m11_s2;
	logic signed [SHIFT_W-1:0] shx_s2;
	logic signed [SHIFT_W-1:0] shy_s2;

	// advance everything unless the output word is held
	assign adv       = !valid_o_s2 || mtx.ready;
	assign srt.ready = adv;

	// second and third quadrant: move by a half turn, negate sin and cos later
	assign fold_flip  = srt.angle[ANGLE_W-1] ^ srt.angle[ANGLE_W-2];
	assign fold_angle = {srt.angle[ANGLE_W-1] ^ fold_flip, srt.angle[ANGLE_W-2:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_p[0] <= 1'b0;
		end else if (adv) begin
			valid_p[0] <= srt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_p[0] <= CORDIC_GAIN_Q30;
			y_p[0] <= '0;
			z_p[0] <= {{(Z_W-ANGLE_W-16){fold_angle[ANGLE_W-1]}}, fold_angle, 16'b0};
			side_p[0].scale_x <= srt.scale_x;
			side_p[0].scale_y <= srt.scale_y;
			side_p[0].shift_x <= srt.shift_x;
			side_p[0].shift_y <= srt.shift_y;
			side_p[0].flip    <= fold_flip;
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_cordic
		srt_cordic_stage #(.STEP(g)) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.valid_in  (valid_p[g]),
			.x_in      (x_p[g]),
			.y_in      (y_p[g]),
			.z_in      (z_p[g]),
			.side_in   (side_p[g]),
			.valid_out (valid_p[g+1]),
			.x_out     (x_p[g+1]),
			.y_out     (y_p[g+1]),
			.z_out     (z_p[g+1]),
			.side_out  (side_p[g+1])
		);
	end

	assign cos_v = side_p[N].flip ? -x_p[N] : x_p[N];
	assign sin_v = side_p[N].flip ? -y_p[N] : y_p[N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_m_s1 <= 1'b0;
			valid_o_s2 <= 1'b0;
		end else if (adv) begin
			valid_m_s1 <= valid_p[N];
			valid_o_s2 <= valid_m_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p00_s1 <= PROD_W'(cos_v) * PROD_W'(side_p[N].scale_x);
			p01_s1 <= PROD_W'(sin_v) * PROD_W'(side_p[N].scale_y);
			p10_s1 <= PROD_W'(sin_v) * PROD_W'(side_p[N].scale_x);
			p11_s1 <= PROD_W'(cos_v) * PROD_W'(side_p[N].scale_y);
			shx_s1 <= side_p[N].shift_x;
			shy_s1 <= side_p[N].shift_y;

			m00_s2 <= round_sat((PROD_W+2)'(p00_s1));
			m01_s2 <= round_sat(-((PROD_W+2)'(p01_s1)));
			m10_s2 <= round_sat((PROD_W+2)'(p10_s1));
			m11_s2 <= round_sat((PROD_W+2)'(p11_s1));
			shx_s2 <= shx_s1;
			shy_s2 <= shy_s1;
		end
	end

	assign mtx.valid       = valid_o_s2;
	assign mtx.m_row0_col0 = m00_s2;
	assign mtx.m_row0_col1 = m01_s2;
	assign mtx.m_row0_col2 = shx_s2;
	assign mtx.m_row1_col0 = m10_s2;
	assign mtx.m_row1_col1 = m11_s2;
	assign mtx.m_row1_col2 = shy_s2;
endmodule
